FILE: design/assert_macros.svh
// Assertion macros shared by the divider checker.
// Every macro samples on clk; the checker supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define IDIV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define IDIV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/idiv_pkg.sv
// Divider package: width constants, op codes and the pipeline word.
// No dependencies; used by every divider module.
package idiv_pkg;

  localparam int WIDTH   = 64;  // datapath width, 8..64
  localparam int FIELD_W = 64;  // port width of operands and result
  localparam int STEPS   = WIDTH;

  typedef enum logic [1:0] {
    OP_UDIV = 2'd0,
    OP_UREM = 2'd1,
    OP_SDIV = 2'd2,
    OP_SREM = 2'd3
  } op_t;

  // One in-flight division.
  typedef struct packed {
    logic [WIDTH-1:0] rem;       // partial remainder
    logic [WIDTH-1:0] nq;        // dividend bits leave at top, quotient bits enter at bottom
    logic [WIDTH-1:0] dsr;       // divisor magnitude
    logic             neg_q;     // negate quotient at the end
    logic             neg_r;     // negate remainder at the end
    logic             want_rem;  // result is remainder
    logic             dz;        // divisor is zero
  } word_t;

endpackage

FILE: design/idiv_pre.sv
// Divider input stage: op decode, operand magnitudes, zero divisor flag.
// Depends on idiv_pkg.
module idiv_pre (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [idiv_pkg::FIELD_W-1:0] dividend,
  input  logic [idiv_pkg::FIELD_W-1:0] divisor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output idiv_pkg::word_t              out_word
);
  import idiv_pkg::*;

  logic [WIDTH-1:0] a, b, am, bm;
  logic             sgn, a_neg, b_neg;
  op_t              op_dec;
  word_t            word_next;
  logic             valid;
  word_t            word;

  always_comb begin
    op_dec = op_t'(op);
    a      = dividend[WIDTH-1:0];
    b      = divisor[WIDTH-1:0];
    sgn    = (op_dec == OP_SDIV) || (op_dec == OP_SREM);
    a_neg  = sgn & a[WIDTH-1];
    b_neg  = sgn & b[WIDTH-1];
    am     = a_neg ? (~a + WIDTH'(1)) : a;
    bm     = b_neg ? (~b + WIDTH'(1)) : b;

    word_next.rem      = '0;
    word_next.nq       = am;
    word_next.dsr      = bm;
    word_next.neg_q    = a_neg ^ b_neg;
    word_next.neg_r    = a_neg;
    word_next.want_rem = (op_dec == OP_UREM) || (op_dec == OP_SREM);
    word_next.dz       = (b == '0);
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= word_next;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

FILE: design/idiv_step.sv
// One restoring division step: one quotient bit, MSB first.
// Depends on idiv_pkg.
module idiv_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  idiv_pkg::word_t in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output idiv_pkg::word_t out_word
);
  import idiv_pkg::*;

  logic [WIDTH:0] shifted, diff;  // extra bit holds the carry out of the remainder
  logic           ge;
  word_t          word_next;
  logic           valid;
  word_t          word;

  always_comb begin
    shifted           = {in_word.rem, in_word.nq[WIDTH-1]};
    diff              = shifted - {1'b0, in_word.dsr};
    ge                = (shifted >= {1'b0, in_word.dsr});
    word_next         = in_word;
    word_next.rem     = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    word_next.nq      = {in_word.nq[WIDTH-2:0], ge};
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= word_next;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

FILE: design/idiv_post.sv
// Divider output stage: quotient/remainder select, sign fixup, zero divisor.
// Depends on idiv_pkg.
module idiv_post (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  idiv_pkg::word_t              in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [idiv_pkg::FIELD_W-1:0] result
);
  import idiv_pkg::*;

  logic [WIDTH-1:0]   sel;
  logic [FIELD_W-1:0] result_next;
  logic               valid;

  always_comb begin
    if (in_word.dz) begin
      sel = '0;
    end else if (in_word.want_rem) begin
      sel = in_word.neg_r ? (~in_word.rem + WIDTH'(1)) : in_word.rem;
    end else begin
      sel = in_word.neg_q ? (~in_word.nq + WIDTH'(1)) : in_word.nq;
    end
    result_next = FIELD_W'(sel);
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result <= result_next;
    end
  end

  assign out_valid = valid;

endmodule

FILE: design/int64_divider.sv
// int64_divider: pipelined restoring divider, signed and unsigned, quotient or remainder.
// Registers on the way to out_valid: the pre stage, the step stages, the post stage.
// Throughput: one word per cycle unless stalled; a register per quotient bit sets depth.
// Backpressure: each stage holds its word and takes a new one once it empties, so
// bubbles close up and input keeps flowing while a result waits at the output.
// Reset: rst (sync, active high) clears every stage valid bit; data is not reset.
module int64_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [idiv_pkg::FIELD_W-1:0] dividend,
  input  logic [idiv_pkg::FIELD_W-1:0] divisor,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [idiv_pkg::FIELD_W-1:0] result
);
  import idiv_pkg::*;

  // Stage i feeds stage i+1. stg[0] is the pre stage output, stg[STEPS] the last step.
  word_t stg [0:STEPS];
  logic  vld [0:STEPS];
  // rdy[i]: the consumer of stg[i] can take a word. rdy[STEPS] is the post stage.
  logic  rdy [0:STEPS];
  logic  pre_ready;

  // Operand conditioning: magnitudes for signed ops, sign fixup flags.
  idiv_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (pre_ready),
    .op        (op),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_word  (stg[0])
  );

  assign in_stall = !pre_ready;

  // One quotient bit per stage, MSB first. The ready chain runs back through
  // all stages combinationally; it is only an AND/OR per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    idiv_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_word   (stg[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_word  (stg[i+1])
    );
  end

  // Result select and sign restore; its register is the output register.
  idiv_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[STEPS]),
    .in_ready  (rdy[STEPS]),
    .in_word   (stg[STEPS]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .result    (result)
  );

endmodule

FILE: design/idiv_checker.sv
// Port-level checks for int64_divider, bound to the top level.
// Depends on idiv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module idiv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [idiv_pkg::FIELD_W-1:0] result
);

  // A held result stays put until taken.
  `IDIV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(result), "result dropped or changed while stalled")

  // Reset empties the pipe.
  `IDIV_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "out_valid after reset")

  // Input only stalls when the output is backed up.
  `IDIV_ASSERT(a_no_false_stall, (!out_valid || !out_stall) |-> !in_stall, "input stalled with output free")

  // A new stall at the input needs a stalled result behind it.
  `IDIV_ASSERT(a_stall_cause, $rose(in_stall) |-> out_valid && out_stall, "input stall without backpressure")

endmodule

bind int64_divider idiv_checker u_idiv_checker (.*);

FILE: test/tb_int64_divider.sv
`timescale 1ns / 100ps
// tb_int64_divider: self-checking bench for the pipelined restoring divider.
// Depends on idiv_pkg (width, op codes) and the int64_divider top level only.
module tb_int64_divider;
  import idiv_pkg::*;

  // Pipeline depth: WIDTH stages plus input/output regs.
  localparam int LATENCY     = WIDTH + 2;
  // Cycles with no word moving on either side before we call it hung.
  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_WORDS  = 375;  // per phase, three phases

  // Operand mask and sign bit at the configured datapath width.
  localparam logic [FIELD_W-1:0] WMASK = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
  localparam logic [FIELD_W-1:0] WMIN  = 64'd1 << (WIDTH - 1);
  localparam logic [FIELD_W-1:0] WMAX  = WMIN - 64'd1;
  localparam logic [FIELD_W-1:0] NEG2  = -64'd2;
  localparam logic [FIELD_W-1:0] NEG7  = -64'd7;

  typedef struct {
    op_t                op;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } div_req_t;

  typedef struct {
    div_req_t           req;
    logic [FIELD_W-1:0] res;
  } div_exp_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         op        = 2'd0;
  logic [FIELD_W-1:0] dividend  = '0;
  logic [FIELD_W-1:0] divisor   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] result;

  div_req_t div_requests[$];       // words not yet offered to the divider
  div_exp_t results_in_flight[$];  // accepted divisions, oldest first
  div_req_t driven_req;
  div_exp_t accepted_div;
  div_exp_t oldest_div;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;

  always #6 clk = ~clk;

  int64_divider u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  // Expected quotient or remainder. Plain restoring division on magnitudes with a
  // remainder one bit wider than the datapath, so top-bit divisors need no carry trick.
  function automatic logic [FIELD_W-1:0] quot_or_rem(div_req_t rq);
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] q;
    logic [FIELD_W-1:0] res;
    logic [FIELD_W:0]   r;
    logic               is_signed;
    logic               a_neg;
    logic               b_neg;
    int                 k;
    a         = rq.dividend & WMASK;
    b         = rq.divisor & WMASK;
    is_signed = (rq.op == OP_SDIV) || (rq.op == OP_SREM);
    a_neg     = is_signed && a[WIDTH-1];
    b_neg     = is_signed && b[WIDTH-1];
    if (a_neg) a = (~a + 64'd1) & WMASK;
    if (b_neg) b = (~b + 64'd1) & WMASK;
    q = '0;
    r = '0;
    // zero divisor: loop skipped, both quotient and remainder stay 0
    if (b != '0) begin
      for (k = WIDTH - 1; k >= 0; k--) begin
        r = {r[FIELD_W-1:0], a[k]};
        if (r >= {1'b0, b}) begin
          r    = r - {1'b0, b};
          q[k] = 1'b1;
        end
      end
    end
    // quotient sign from the operand signs, remainder follows the dividend;
    // MIN / -1 wraps back to MIN through the negate
    if (rq.op == OP_UDIV || rq.op == OP_SDIV) res = (a_neg != b_neg) ? -q : q;
    else res = a_neg ? -r[FIELD_W-1:0] : r[FIELD_W-1:0];
    return res & WMASK;
  endfunction

  // Operands: full random, scaled-down values of both signs (varied quotient lengths),
  // small values of either sign and the width extremes. Bits above WIDTH are left
  // random on purpose; the divider has to ignore them.
  function automatic logic [FIELD_W-1:0] pick_operand();
    logic [FIELD_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4, 5: v = v >> $urandom_range(63);
      6:    v = 64'($urandom_range(15));
      7:    v = -64'($urandom_range(15));
      8: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 64'd1;
          2: v = WMASK;
          3: v = WMIN;
          default: v = WMAX;
        endcase
      end
      default: v = -(v >> $urandom_range(63));
    endcase
    return v;
  endfunction

  task automatic add_div(op_t o, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    div_req_t rq;
    rq.op       = o;
    rq.dividend = a;
    rq.divisor  = b;
    div_requests.push_back(rq);
  endtask

  // Holds until every queued word is accepted and every result is back.
  task automatic wait_drained();
    @(negedge clk);
    while (div_requests.size() != 0 || in_valid || results_in_flight.size() != 0)
      @(negedge clk);
  endtask

  task automatic flag_error(string what);
    $display("[%0t] ERROR %s", $time, what);
    error_count++;
  endtask

  // Driver: a word stays on the port until taken. On the edge that takes it the
  // next one goes up (or valid drops), so valid only ever sees one NBA per edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        accepted_div.req = driven_req;
        accepted_div.res = quot_or_rem(driven_req);
        results_in_flight.push_back(accepted_div);
      end
      if (div_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        driven_req = div_requests.pop_front();
        in_valid <= 1'b1;
        op       <= driven_req.op;
        dividend <= driven_req.dividend;
        divisor  <= driven_req.divisor;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure, and each taken result is checked in order.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (results_in_flight.size() == 0) begin
          flag_error($sformatf("unexpected result %h", result));
        end else begin
          oldest_div = results_in_flight.pop_front();
          if (result !== oldest_div.res)
            flag_error($sformatf("%s %h / %h: got %h, want %h", oldest_div.req.op.name(),
                                 oldest_div.req.dividend, oldest_div.req.divisor,
                                 result, oldest_div.res));
        end
      end
    end
  end

  // Watchdog: any word moving on either side resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    int send_pct[3];
    int recv_pct[3];
    // Phase 0: output mostly stalled, so the pipe fills and in_stall pushes back.
    // Phase 1: sparse input, bubbles through the stages. Phase 2: full rate.
    send_pct = '{7, 86, 0};
    recv_pct = '{86, 7, 0};

    // Directed words: zero divisor in every mode
    add_div(OP_UDIV, '0, '0);
    add_div(OP_UREM, WMASK, '0);
    add_div(OP_SDIV, WMIN, '0);
    add_div(OP_SREM, 64'd5, '0);
    // most negative over minus one: quotient wraps, remainder is zero
    add_div(OP_SDIV, WMIN, WMASK);
    add_div(OP_SREM, WMIN, WMASK);
    // unsigned extremes and divisors with the top bit set
    add_div(OP_UDIV, WMASK, 64'd1);
    add_div(OP_UREM, WMASK, WMASK);
    add_div(OP_UDIV, WMASK, WMIN);
    add_div(OP_UREM, WMASK, WMIN | 64'd1);
    add_div(OP_UDIV, '0, WMASK);
    add_div(OP_UDIV, 64'd3, 64'd10);
    add_div(OP_UREM, 64'd3, 64'd10);
    // truncation toward zero with a negative dividend, divisor or both
    add_div(OP_SDIV, 64'd7, NEG2);
    add_div(OP_SREM, 64'd7, NEG2);
    add_div(OP_SDIV, NEG7, 64'd2);
    add_div(OP_SREM, NEG7, 64'd2);
    add_div(OP_SDIV, NEG7, NEG2);
    add_div(OP_SREM, NEG7, NEG2);
    add_div(OP_SDIV, WMAX, 64'd1);
    add_div(OP_SDIV, WMIN, 64'd1);
    add_div(OP_SDIV, WMIN, WMIN);
    add_div(OP_SREM, WMIN, WMAX);
    add_div(OP_UDIV, 64'hA5A5_A5A5_A5A5_A5A5, 64'h0000_0000_5A5A_5A5A);
    add_div(OP_SREM, 64'h5A5A_5A5A_5A5A_5A5A, 64'hFFFF_FFFF_A5A5_A5A5);

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      for (n = 0; n < RAND_WORDS; n++)
        add_div(op_t'($urandom_range(3)), pick_operand(), pick_operand());
      if (ph == 0) begin
        repeat (10) @(posedge clk);
        rst <= 1'b0;
      end
      // sender holds off here until the pipe has fully emptied
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: int64_divider.f
+incdir+design
design/idiv_pkg.sv
design/idiv_pre.sv
design/idiv_step.sv
design/idiv_post.sv
design/int64_divider.sv
design/idiv_checker.sv
test/tb_int64_divider.sv
